// ----- rtl/hef_pkg.sv -----
`timescale 1ns / 1ps
package hef_pkg;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;
   localparam int IDX_W          = 18;
   localparam int ROUND_W        = 19;
   localparam int CFG_W          = 10;
   localparam int CMD_DEPTH      = 4;
   localparam int RSP_DEPTH      = 2;

   localparam logic [1:0] CLS_NONE   = 2'd0;
   localparam logic [1:0] CLS_WEAK   = 2'd1;
   localparam logic [1:0] CLS_STRONG = 2'd2;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic [1:0] OFF_NEG  = 2'b11;
   localparam logic [1:0] OFF_ZERO = 2'b00;
   localparam logic [1:0] OFF_POS  = 2'b01;

   localparam logic [1:0] NB_DX [8] = '{OFF_NEG, OFF_ZERO, OFF_POS, OFF_NEG,
                                        OFF_POS, OFF_NEG, OFF_ZERO, OFF_POS};
   localparam logic [1:0] NB_DY [8] = '{OFF_NEG, OFF_NEG, OFF_NEG, OFF_ZERO,
                                        OFF_ZERO, OFF_POS, OFF_POS, OFF_POS};

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_RUN   = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_SEED,
      ST_ROUND,
      ST_POP,
      ST_LOAD,
      ST_NB_RD,
      ST_NB_CHK
   } state_type;

   typedef struct packed {
      mode_type         mode;
      logic [IDX_W-1:0] index;
      logic [1:0]       cls;
      logic             oob;
   } cmd_type;

   typedef struct packed {
      logic [1:0]         cls;
      logic [ROUND_W-1:0] rounds;
      logic               status;
   } rsp_type;

endpackage

// ----- rtl/hef_fifo.sv -----
`timescale 1ns / 1ps
module hef_fifo
   import hef_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign dout    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- rtl/hef_front.sv -----
`timescale 1ns / 1ps
module hef_front
   import hef_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int WD_W  = $clog2(MAX_WIDTH + 1),
   localparam int HD_W  = $clog2(MAX_HEIGHT + 1),
   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_mode,
   input  logic [IDX_W-1:0] req_pixel_index,
   input  logic [1:0]       req_pixel_class_in,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_data,
   output logic [WD_W-1:0]  img_w,
   output logic [HD_W-1:0]  img_h,
   output logic [CNT_W-1:0] pix_count,
   input  logic             cmd_pop,
   output cmd_type          cmd,
   output logic             cmd_empty
);

   localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

   logic [WD_W-1:0]  w_ff, w_nxt;
   logic [HD_W-1:0]  h_ff, h_nxt;
   logic [CNT_W-1:0] p_ff;
   logic [CNT_W-1:0] w_ext, h_ext;
   cmd_type          cmd_new;
   logic             csr_fire;

   function automatic logic [WD_W-1:0] eff_w(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return WD_W'(1);
      end
      if (int'(v) > MAX_WIDTH) begin
         return WD_W'(MAX_WIDTH);
      end
      return WD_W'(v);
   endfunction

   function automatic logic [HD_W-1:0] eff_h(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return HD_W'(1);
      end
      if (int'(v) > MAX_HEIGHT) begin
         return HD_W'(MAX_HEIGHT);
      end
      return HD_W'(v);
   endfunction

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign img_w     = w_ff;
   assign img_h     = h_ff;
   assign pix_count = p_ff;

   always_comb begin
      w_nxt = w_ff;
      h_nxt = h_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_WIDTH:  w_nxt = eff_w(csr_data);
            CSR_HEIGHT: h_nxt = eff_h(csr_data);
            default:    w_nxt = w_ff;
         endcase
      end
      w_ext = CNT_W'(w_nxt);
      h_ext = CNT_W'(h_nxt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= eff_w(CFG_W'(DEF_MAX_WIDTH));
         h_ff <= eff_h(CFG_W'(DEF_MAX_HEIGHT));
         p_ff <= CNT_W'(CNT_W'(eff_w(CFG_W'(DEF_MAX_WIDTH)))
                        * CNT_W'(eff_h(CFG_W'(DEF_MAX_HEIGHT))));
      end else if (csr_fire) begin
         w_ff <= w_nxt;
         h_ff <= h_nxt;
         p_ff <= CNT_W'(w_ext * h_ext);
      end
   end

   // classify: flag indices outside the image
   always_comb begin
      cmd_new.mode  = mode_type'(req_mode);
      cmd_new.index = req_pixel_index;
      cmd_new.cls   = req_pixel_class_in;
      cmd_new.oob   = (CMP_W'(req_pixel_index) >= CMP_W'(p_ff));
   end

   hef_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .din   (cmd_new),
      .full  (req_full),
      .pop   (cmd_pop),
      .dout  (cmd),
      .empty (cmd_empty)
   );

endmodule

// ----- rtl/hef_back.sv -----
`timescale 1ns / 1ps
module hef_back
   import hef_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int WD_W  = $clog2(MAX_WIDTH + 1),
   localparam int HD_W  = $clog2(MAX_HEIGHT + 1),
   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [WD_W-1:0]  img_w,
   input  logic [HD_W-1:0]  img_h,
   input  logic [CNT_W-1:0] pix_count,
   input  cmd_type          cmd,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   input  logic             rsp_pop,
   output rsp_type          rsp,
   output logic             rsp_empty
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = CNT_W - 1;
   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int QW     = ADDR_W + XW + YW;

   logic [1:0]        store_mem [DEPTH];
   logic [QW-1:0]     queue_mem [DEPTH];
   logic [1:0]        store_q_ff;
   logic [QW-1:0]     queue_q_ff;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  head_ff, head_in, tail_ff, tail_in, lvl_end_ff, lvl_end_in;
   logic [CNT_W-1:0]  rounds_ff, rounds_in, s_idx_ff, s_idx_in;
   logic [XW-1:0]     s_x_ff, s_x_in, cur_x_ff, cur_x_in, nb_x_ff, nb_x_in, sp_x_ff, sp_x_in;
   logic [YW-1:0]     s_y_ff, s_y_in, cur_y_ff, cur_y_in, nb_y_ff, nb_y_in, sp_y_ff, sp_y_in;
   logic [ADDR_W-1:0] cur_idx_ff, cur_idx_in, nb_idx_ff, nb_idx_in, sp_idx_ff, sp_idx_in;
   logic              sp_vld_ff, sp_vld_in, nb_vld_ff, nb_vld_in, rd_oob_ff, rd_oob_in;
   logic [2:0]        k_ff, k_in;

   logic              st_we;
   logic [ADDR_W-1:0] st_wa, st_ra;
   logic [1:0]        st_wd;
   logic              q_we;
   logic [ADDR_W-1:0] q_wa, q_ra;
   logic [QW-1:0]     q_wd;

   logic              rsp_push, rsp_full;
   rsp_type           rsp_new;

   logic [XW-1:0]     w_m1;
   logic [YW-1:0]     h_m1;
   logic [ADDR_W-1:0] w_a, row_idx;
   logic [1:0]        dx, dy;
   logic              inb;

   assign w_m1 = XW'(img_w - 1'b1);
   assign h_m1 = YW'(img_h - 1'b1);
   assign w_a  = ADDR_W'(img_w);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      lvl_end_in = lvl_end_ff;
      rounds_in  = rounds_ff;
      s_idx_in   = s_idx_ff;
      s_x_in     = s_x_ff;
      s_y_in     = s_y_ff;
      sp_vld_in  = 1'b0;
      sp_idx_in  = sp_idx_ff;
      sp_x_in    = sp_x_ff;
      sp_y_in    = sp_y_ff;
      cur_idx_in = cur_idx_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      nb_idx_in  = nb_idx_ff;
      nb_x_in    = nb_x_ff;
      nb_y_in    = nb_y_ff;
      nb_vld_in  = nb_vld_ff;
      rd_oob_in  = rd_oob_ff;
      k_in       = k_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp_new    = '0;
      st_we      = 1'b0;
      st_wa      = nb_idx_ff;
      st_wd      = CLS_STRONG;
      st_ra      = nb_idx_ff;
      q_we       = 1'b0;
      q_wa       = tail_ff[ADDR_W-1:0];
      q_wd       = {sp_idx_ff, sp_x_ff, sp_y_ff};
      q_ra       = head_ff[ADDR_W-1:0];

      dx      = NB_DX[k_ff];
      dy      = NB_DY[k_ff];
      inb     = !(dx == OFF_NEG && cur_x_ff == '0) && !(dx == OFF_POS && cur_x_ff == w_m1)
             && !(dy == OFF_NEG && cur_y_ff == '0) && !(dy == OFF_POS && cur_y_ff == h_m1);
      row_idx = (dy == OFF_NEG) ? ADDR_W'(cur_idx_ff - w_a)
              : (dy == OFF_POS) ? ADDR_W'(cur_idx_ff + w_a) : cur_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               unique case (cmd.mode)
                  MODE_WRITE: begin
                     st_we          = !cmd.oob;
                     st_wa          = ADDR_W'(cmd.index);
                     st_wd          = cmd.cls;
                     rsp_push       = 1'b1;
                     rsp_new.status = cmd.oob;
                  end
                  MODE_READ: begin
                     st_ra     = ADDR_W'(cmd.index);
                     rd_oob_in = cmd.oob;
                     state_in  = ST_RD_WAIT;
                  end
                  MODE_RUN: begin
                     s_idx_in  = '0;
                     s_x_in    = '0;
                     s_y_in    = '0;
                     head_in   = '0;
                     tail_in   = '0;
                     rounds_in = '0;
                     state_in  = ST_SEED;
                  end
                  MODE_NOP: begin
                     rsp_push = 1'b1;
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            rsp_push       = 1'b1;
            rsp_new.cls    = rd_oob_ff ? CLS_NONE : store_q_ff;
            rsp_new.status = rd_oob_ff;
            state_in       = ST_IDLE;
         end
         ST_SEED: begin
            if (s_idx_ff < pix_count) begin
               st_ra     = s_idx_ff[ADDR_W-1:0];
               sp_vld_in = 1'b1;
               sp_idx_in = s_idx_ff[ADDR_W-1:0];
               sp_x_in   = s_x_ff;
               sp_y_in   = s_y_ff;
               s_idx_in  = CNT_W'(s_idx_ff + 1'b1);
               if (s_x_ff == w_m1) begin
                  s_x_in = '0;
                  s_y_in = YW'(s_y_ff + 1'b1);
               end else begin
                  s_x_in = XW'(s_x_ff + 1'b1);
               end
            end else if (!sp_vld_ff) begin
               state_in = ST_ROUND;
            end
            if (sp_vld_ff && store_q_ff == CLS_STRONG) begin
               q_we    = 1'b1;
               tail_in = CNT_W'(tail_ff + 1'b1);
            end
         end
         ST_ROUND: begin
            if (head_ff == tail_ff) begin
               rsp_push       = 1'b1;
               rsp_new.rounds = ROUND_W'(rounds_ff);
               state_in       = ST_IDLE;
            end else begin
               lvl_end_in = tail_ff;
               rounds_in  = CNT_W'(rounds_ff + 1'b1);
               state_in   = ST_POP;
            end
         end
         ST_POP: begin
            if (head_ff == lvl_end_ff) begin
               state_in = ST_ROUND;
            end else begin
               head_in  = CNT_W'(head_ff + 1'b1);
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            {cur_idx_in, cur_x_in, cur_y_in} = queue_q_ff;
            k_in     = '0;
            state_in = ST_NB_RD;
         end
         ST_NB_RD: begin
            nb_vld_in = inb;
            nb_idx_in = (dx == OFF_NEG) ? ADDR_W'(row_idx - 1'b1)
                      : (dx == OFF_POS) ? ADDR_W'(row_idx + 1'b1) : row_idx;
            nb_x_in   = XW'(cur_x_ff + {{(XW-2){dx[1]}}, dx});
            nb_y_in   = YW'(cur_y_ff + {{(YW-2){dy[1]}}, dy});
            st_ra     = nb_idx_in;
            state_in  = ST_NB_CHK;
         end
         ST_NB_CHK: begin
            if (nb_vld_ff && store_q_ff == CLS_WEAK) begin
               st_we   = 1'b1;
               q_we    = 1'b1;
               q_wd    = {nb_idx_ff, nb_x_ff, nb_y_ff};
               tail_in = CNT_W'(tail_ff + 1'b1);
            end
            if (k_ff == 3'd7) begin
               state_in = ST_POP;
            end else begin
               k_in     = 3'(k_ff + 1'b1);
               state_in = ST_NB_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         sp_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         sp_vld_ff <= sp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_end_ff <= lvl_end_in;
      rounds_ff  <= rounds_in;
      s_idx_ff   <= s_idx_in;
      s_x_ff     <= s_x_in;
      s_y_ff     <= s_y_in;
      sp_idx_ff  <= sp_idx_in;
      sp_x_ff    <= sp_x_in;
      sp_y_ff    <= sp_y_in;
      cur_idx_ff <= cur_idx_in;
      cur_x_ff   <= cur_x_in;
      cur_y_ff   <= cur_y_in;
      nb_idx_ff  <= nb_idx_in;
      nb_x_ff    <= nb_x_in;
      nb_y_ff    <= nb_y_in;
      nb_vld_ff  <= nb_vld_in;
      rd_oob_ff  <= rd_oob_in;
      k_ff       <= k_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_wa] <= st_wd;
      end
      store_q_ff <= store_mem[st_ra];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_wa] <= q_wd;
      end
      queue_q_ff <= queue_mem[q_ra];
   end

   hef_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_new),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .dout  (rsp),
      .empty (rsp_empty)
   );

   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("frontier head passed tail");

   a_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> (head_ff <= lvl_end_ff))
      else $error("frontier head passed end of round");

   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_RD_WAIT) |-> (tail_ff <= pix_count))
      else $error("frontier grew beyond image size");

   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result word dropped");

   a_promote: assert property (@(posedge clock) disable iff (reset)
      (st_we && state_ff == ST_NB_CHK) |-> (nb_vld_ff && store_q_ff == CLS_WEAK))
      else $error("promotion of a pixel that is not weak");

endmodule

// ----- rtl/hysteresis_edge_flood.sv -----
`timescale 1ns / 1ps
// Hysteresis edge tracking over a class map held in an on-chip store of
// MAX_WIDTH*MAX_HEIGHT two-bit entries (0 none, 1 weak, 2 strong, 3 other).
// Items enter through a short command queue and are executed one at a time
// by a back end that owns the store and the frontier memory; results leave
// through a result queue. A write item is done in the idle state of the back
// end and a read item passes through a read-wait state. A run item first
// sweeps over every pixel to seed the frontier with the strong pixels; in
// each flood round every frontier pixel is popped and loaded and then visits
// its eight neighbours one at a time through the single read port of the
// class store, promoting weak neighbours to strong. Entries never written
// must not be read or lie inside the image when a run item is issued.
module hysteresis_edge_flood
   import hef_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_mode,
   input  logic [IDX_W-1:0]   req_pixel_index,
   input  logic [1:0]         req_pixel_class_in,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_pixel_class_out,
   output logic [ROUND_W-1:0] rsp_round_count,
   output logic               rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [CFG_W-1:0]   csr_data
);

   localparam int WD_W  = $clog2(MAX_WIDTH + 1);
   localparam int HD_W  = $clog2(MAX_HEIGHT + 1);
   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;

   logic [WD_W-1:0]  img_w;
   logic [HD_W-1:0]  img_h;
   logic [CNT_W-1:0] pix_count;
   cmd_type          cmd;
   logic             cmd_empty, cmd_pop;
   rsp_type          rsp;

   hef_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (push),
      .req_full           (full),
      .req_mode           (req_mode),
      .req_pixel_index    (req_pixel_index),
      .req_pixel_class_in (req_pixel_class_in),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .img_w              (img_w),
      .img_h              (img_h),
      .pix_count          (pix_count),
      .cmd_pop            (cmd_pop),
      .cmd                (cmd),
      .cmd_empty          (cmd_empty)
   );

   hef_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .img_w     (img_w),
      .img_h     (img_h),
      .pix_count (pix_count),
      .cmd       (cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (pop),
      .rsp       (rsp),
      .rsp_empty (empty)
   );

   assign rsp_pixel_class_out = rsp.cls;
   assign rsp_round_count     = rsp.rounds;
   assign rsp_status          = rsp.status;

endmodule
